FILE: src/mvsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice mixer package
// Operation codes and the fixed field widths that the mixer's modules share.
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int SMP_IN_W = 16;
    localparam int LEN_W    = 17;
    localparam int POS_W    = 16;
    localparam int MIX_W    = 19;
    localparam int COUNT_W  = 4;

    localparam logic [LEN_W-1:0] MAX_CLIP = 17'd65536;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

endpackage

FILE: src/mvsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/multi_voice_sample_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-voice sample mixer
// Plays stored PCM clips through VOICE_COUNT voice slots and sums one output
// frame per tick transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  input     in_valid / in_stall  operation, address, sample_in, clip_length,
//                                 loop_flag, start_paused
//  output    out_valid/out_stall  mix_out, accepted, active_voices
//
//  A write or start transaction passes from acceptance through the
//  preparation state and the finish state, which loads the result register
//  once the output can take it; a tick runs the preparation state, one
//  voice-memory read per slot issued back to back, a drain of the record
//  update, the sample-memory read and the accumulator, and the finish state.
//  The block works on one transaction at a time: in_stall is low only while
//  the sequencer is idle. The result register lets a new transaction enter
//  while the previous result is still stalled at the output.
//  Reset clears the slot-in-use flags, the voice count, the sequencer and
//  the output valid; neither memory is cleared, since a free slot's record
//  is never used and sample words are undefined until written.
//
// Structure: the voice records live in a small RAM (one entry per slot) and
// the sample words in a large RAM. A tick streams the voice RAM in slot
// order; each record read in the previous cycle is advanced and written
// back at once, while the sample read for that voice is issued. Reads run
// ahead of write-backs by exactly one slot, so no two accesses to the same
// entry ever overlap.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer
    import mvsm_pkg::*;
#(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_WORDS = 65536,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic [ADDR_W-1:0]          address,
    input  logic signed [SMP_IN_W-1:0] sample_in,
    input  logic [LEN_W-1:0]           clip_length,
    input  logic                       loop_flag,
    input  logic                       start_paused,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [MIX_W-1:0]    mix_out,
    output logic                       accepted,
    output logic [COUNT_W-1:0]         active_voices
);

    // Sample memory address width and the width used while reducing an
    // address modulo the memory size.
    localparam int AW    = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int RW    = AW + 9;
    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int VC_W  = $clog2(VOICE_COUNT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // One voice slot as stored in the voice RAM. The sample address is kept
    // already reduced modulo the memory size, so a tick only needs an
    // increment with wrap.
    typedef struct packed {
        logic [AW-1:0]    base;
        logic [AW-1:0]    cur;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             loop;
        logic             paused;
    } voice_rec_t;

    localparam int VREC_W = $bits(voice_rec_t);

    // Address modulo the memory size by restoring subtraction of shifted
    // copies of the size. The user must keep the size at least 256, which the
    // block does not enforce; then eight steps cover every 16-bit address.
    function automatic logic [AW-1:0] addr_mod(input logic [ADDR_W-1:0] a);
        logic [RW-1:0] v;
        v = RW'(a);
        for (int k = 7; k >= 0; k--)
        begin
            if (v >= (RW'(SAMPLE_WORDS) << k))
            begin
                v = v - (RW'(SAMPLE_WORDS) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // Sequencer and captured transaction.
    logic [1:0]                state_reg, state_next;
    logic [OP_W-1:0]           op_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic signed [SMP_IN_W-1:0] smp_reg;
    logic [LEN_W-1:0]          len_reg;
    logic                      loop_reg;
    logic                      paused_reg;

    // Slot flags live in flip-flops so that the free-slot search and the
    // active check need no memory read.
    logic [VOICE_COUNT-1:0]    in_use_reg;
    logic [VC_W-1:0]           cnt_reg;

    // Tick pipeline.
    logic [VC_W-1:0]           iss_cnt_reg;
    logic                      s1_valid_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic                      s2_valid_reg;
    logic signed [MIX_W-1:0]   acc_reg;
    logic                      res_ok_reg;

    // Result register.
    logic                      out_valid_reg;
    logic signed [MIX_W-1:0]   mix_reg;
    logic                      ok_reg;
    logic [COUNT_W-1:0]        act_reg;

    // Memory ports.
    logic                      vram_we;
    logic [IDX_W-1:0]          vram_waddr;
    logic [VREC_W-1:0]         vram_wdata;
    logic [IDX_W-1:0]          vram_raddr;
    logic [VREC_W-1:0]         vram_rdata;
    logic                      sram_we;
    logic [AW-1:0]             sram_waddr;
    logic [SAMPLE_BITS-1:0]    sram_wdata;
    logic [AW-1:0]             sram_raddr;
    logic [SAMPLE_BITS-1:0]    sram_rdata;

    // Combinational helpers.
    logic                      in_fire;
    logic                      out_load;
    logic [AW-1:0]             amod;
    logic                      free_found;
    logic [IDX_W-1:0]          free_idx;
    logic                      len_ok;
    logic                      start_ok;
    logic                      iss_go;
    logic                      tick_end;
    voice_rec_t                s1_rec;
    voice_rec_t                new_rec;
    voice_rec_t                wb_rec;
    logic                      s1_act;
    logic [LEN_W-1:0]          pos_inc;
    logic                      s1_wrap;
    logic                      s1_done;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    assign amod   = addr_mod(addr_reg);
    assign len_ok = (len_reg != '0) && (len_reg <= MAX_CLIP);

    // Lowest free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign start_ok = (state_reg == S_PREP) && (op_reg == OP_START) && len_ok && free_found;

    always_comb
    begin
        new_rec.base   = amod;
        new_rec.cur    = amod;
        new_rec.pos    = '0;
        new_rec.len    = len_reg;
        new_rec.loop   = loop_reg;
        new_rec.paused = paused_reg;
    end

    // Stage one of the tick: the voice record read in the previous cycle is
    // advanced. A voice that reaches its length goes back to its base; one
    // that does not loop is finished and its slot is freed.
    assign s1_rec  = voice_rec_t'(vram_rdata);
    assign s1_act  = s1_valid_reg && in_use_reg[s1_idx_reg] && !s1_rec.paused;
    assign pos_inc = {1'b0, s1_rec.pos} + LEN_W'(1);
    assign s1_wrap = (pos_inc >= s1_rec.len);
    assign s1_done = s1_wrap && !s1_rec.loop;

    always_comb
    begin
        wb_rec = s1_rec;
        if (s1_wrap)
        begin
            wb_rec.pos = '0;
            wb_rec.cur = s1_rec.base;
        end
        else
        begin
            wb_rec.pos = pos_inc[POS_W-1:0];
            if (s1_rec.cur == AW'(SAMPLE_WORDS - 1))
            begin
                wb_rec.cur = '0;
            end
            else
            begin
                wb_rec.cur = s1_rec.cur + AW'(1);
            end
        end
    end

    assign iss_go   = (state_reg == S_TICK) && (iss_cnt_reg < VC_W'(VOICE_COUNT));
    assign tick_end = (state_reg == S_TICK) && !iss_go && !s1_valid_reg && !s2_valid_reg;

    // Memory port steering. The voice RAM is written by a start in the
    // preparation cycle and by tick write-backs; both never coincide.
    always_comb
    begin
        vram_raddr = iss_cnt_reg[IDX_W-1:0];
        vram_we    = 1'b0;
        vram_waddr = s1_idx_reg;
        vram_wdata = VREC_W'(wb_rec);
        if (start_ok)
        begin
            vram_we    = 1'b1;
            vram_waddr = free_idx;
            vram_wdata = VREC_W'(new_rec);
        end
        else if (s1_act && !s1_done)
        begin
            vram_we = 1'b1;
        end
    end

    assign sram_we    = (state_reg == S_PREP) && (op_reg == OP_WRITE);
    assign sram_waddr = amod;
    assign sram_wdata = SAMPLE_BITS'(smp_reg);
    assign sram_raddr = s1_rec.cur;

    mvsm_ram #(
        .WIDTH (VREC_W),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    mvsm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (op_reg == OP_TICK)
                begin
                    state_next = S_TICK;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_TICK:
            begin
                if (tick_end)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            cnt_reg       <= '0;
            iss_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= iss_go;
            s2_valid_reg <= s1_act;

            if (state_reg == S_PREP)
            begin
                iss_cnt_reg <= '0;
            end
            else if (iss_go)
            begin
                iss_cnt_reg <= iss_cnt_reg + VC_W'(1);
            end

            if (start_ok)
            begin
                in_use_reg[free_idx] <= 1'b1;
                cnt_reg              <= cnt_reg + VC_W'(1);
            end
            else if (s1_act && s1_done)
            begin
                in_use_reg[s1_idx_reg] <= 1'b0;
                cnt_reg                <= cnt_reg - VC_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= operation;
            addr_reg   <= address;
            smp_reg    <= sample_in;
            len_reg    <= clip_length;
            loop_reg   <= loop_flag;
            paused_reg <= start_paused;
        end

        s1_idx_reg <= iss_cnt_reg[IDX_W-1:0];

        if (state_reg == S_PREP)
        begin
            acc_reg    <= '0;
            res_ok_reg <= (op_reg == OP_WRITE) || (op_reg == OP_TICK) || start_ok;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + MIX_W'(signed'(sram_rdata));
        end

        if (out_load)
        begin
            mix_reg <= acc_reg;
            ok_reg  <= res_ok_reg;
            act_reg <= COUNT_W'(cnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign mix_out       = mix_reg;
    assign accepted      = ok_reg;
    assign active_voices = act_reg;

endmodule

FILE: src/mvsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice mixer port checker
// Watches the mixer's ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mvsm_checker
    import mvsm_pkg::*;
#(
    parameter int VOICE_COUNT = 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [OP_W-1:0]            operation,
    input logic [ADDR_W-1:0]          address,
    input logic signed [SMP_IN_W-1:0] sample_in,
    input logic [LEN_W-1:0]           clip_length,
    input logic                       loop_flag,
    input logic                       start_paused,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [MIX_W-1:0]    mix_out,
    input logic                       accepted,
    input logic [COUNT_W-1:0]         active_voices
);

    // A stalled input transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(operation) && $stable(address)
            && $stable(sample_in) && $stable(clip_length) && $stable(loop_flag)
            && $stable(start_paused))
        else $error("stalled input transaction changed");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mix_out) && $stable(accepted)
            && $stable(active_voices))
        else $error("stalled result changed");

    // A refused transaction carries a zero mix.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> mix_out == '0)
        else $error("refused transaction carries a mix");

    // The slot count never exceeds the number of slots (checked while VOICE_COUNT is below 16).
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (VOICE_COUNT >= 16) || (int'(active_voices) <= VOICE_COUNT))
        else $error("active voice count out of range");

    // A new result only follows a transaction that kept the input stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in flight");

endmodule

bind multi_voice_sample_mixer mvsm_checker #(
    .VOICE_COUNT (VOICE_COUNT)
) u_mvsm_checker (.*);

FILE: tb/sv/multi_voice_sample_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice mixer testbench
// Drives sample writes, voice starts and ticks into the mixer through its
// valid/stall channels and compares every returned frame with a behavioral
// model of the voice slots and sample store, or with a typed-in frame. A
// short directed table covers the field extremes and the refusal cases. A
// long random run of mostly well-formed traffic follows, with bursty input,
// a patterned output stall, one long output hold and one full drain midway.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer_tb;
    import mvsm_pkg::*;

    localparam int VOICES       = 8;
    localparam int WORDS        = 1 << ADDR_W;
    localparam int ITEM_TARGET  = 1100;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AT     = 750;
    localparam int LINGER_LIMIT = 5;
    localparam int TAIL_CYCLES  = 40;

    // Operation 3 is not decoded by the block; it must come back as a
    // refused transaction that changes nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [ADDR_W-1:0]          addr;
        logic signed [SMP_IN_W-1:0] smp;
        logic [LEN_W-1:0]           len;
        logic                       loop_f;
        logic                       paused_f;
    } mix_req_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix;
        logic                    acc;
        logic [COUNT_W-1:0]      count;
    } mix_frame_t;

    typedef struct packed {
        mix_req_t   req;
        logic       known;
        mix_frame_t want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            operation;
    logic [ADDR_W-1:0]          address;
    logic signed [SMP_IN_W-1:0] sample_in;
    logic [LEN_W-1:0]           clip_length;
    logic                       loop_flag;
    logic                       start_paused;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [MIX_W-1:0]    mix_out;
    logic                       accepted;
    logic [COUNT_W-1:0]         active_voices;

    // Behavioral image of the block. Two-state storage starts at zero, which
    // matches the cleared slot flags after reset; the sample store is only ever
    // read where sample_written says a word has been stored.
    bit signed [SMP_IN_W-1:0] sample_image   [WORDS];
    bit                       sample_written [WORDS];
    bit [ADDR_W-1:0]          slot_base      [VOICES];
    bit [LEN_W-1:0]           slot_len       [VOICES];
    bit [POS_W-1:0]           slot_pos       [VOICES];
    bit                       slot_busy      [VOICES];
    bit                       slot_repeat    [VOICES];
    bit                       slot_held      [VOICES];

    mix_frame_t pending_frames [$];
    stim_row_t  directed_rows  [$];

    int issued       = 0;
    int burst_left   = 0;
    int error_count  = 0;
    bit hold_request = 1'b0;

    // Clock: 2 ns period.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multi_voice_sample_mixer #(
        .VOICE_COUNT  (VOICES),
        .SAMPLE_WORDS (WORDS),
        .SAMPLE_BITS  (SMP_IN_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .address       (address),
        .sample_in     (sample_in),
        .clip_length   (clip_length),
        .loop_flag     (loop_flag),
        .start_paused  (start_paused),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mix_out       (mix_out),
        .accepted      (accepted),
        .active_voices (active_voices)
    );

    // Applies one transaction to the model and returns the frame the block
    // must produce for it. Slot order matters: a start claims the lowest free
    // slot, and a tick sums slots from zero upward. Voices that run off the
    // end of a one-shot clip are released only after the whole tick.
    function automatic mix_frame_t mixer_advance(input mix_req_t req);
        mix_frame_t      f;
        int              sum;
        int              n;
        int              s;
        int              nxt;
        bit              claimed;
        bit [ADDR_W-1:0] a;
        bit              ended [VOICES];
        f       = '0;
        sum     = 0;
        n       = 0;
        claimed = 1'b0;
        for (s = 0; s < VOICES; s++)
            ended[s] = 1'b0;
        case (req.op)
            OP_WRITE:
            begin
                sample_image[req.addr]   = req.smp;
                sample_written[req.addr] = 1'b1;
                f.acc = 1'b1;
            end
            OP_START:
            begin
                if (req.len != '0 && req.len <= MAX_CLIP)
                begin
                    for (s = 0; s < VOICES; s++)
                    begin
                        if (!claimed && !slot_busy[s])
                        begin
                            claimed        = 1'b1;
                            slot_busy[s]   = 1'b1;
                            slot_base[s]   = req.addr;
                            slot_len[s]    = req.len;
                            slot_pos[s]    = '0;
                            slot_repeat[s] = req.loop_f;
                            slot_held[s]   = req.paused_f;
                        end
                    end
                end
                f.acc = claimed;
            end
            OP_TICK:
            begin
                for (s = 0; s < VOICES; s++)
                begin
                    if (slot_busy[s] && !slot_held[s])
                    begin
                        // The read address wraps around the sample store.
                        a   = slot_base[s] + slot_pos[s];
                        sum = sum + sample_image[a];
                        nxt = int'(slot_pos[s]) + 1;
                        if (nxt >= int'(slot_len[s]))
                        begin
                            nxt      = 0;
                            ended[s] = !slot_repeat[s];
                        end
                        slot_pos[s] = POS_W'(nxt);
                    end
                end
                for (s = 0; s < VOICES; s++)
                begin
                    if (ended[s])
                    begin
                        slot_busy[s]   = 1'b0;
                        slot_base[s]   = '0;
                        slot_len[s]    = '0;
                        slot_pos[s]    = '0;
                        slot_repeat[s] = 1'b0;
                        slot_held[s]   = 1'b0;
                    end
                end
                f.acc = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (s = 0; s < VOICES; s++)
            if (slot_busy[s])
                n++;
        f.mix   = MIX_W'(sum);
        f.count = COUNT_W'(n);
        return f;
    endfunction

    // Voices that may keep their slot a long time: paused ones, looping ones,
    // and one-shot clips with more than 64 samples still to play. Capping
    // these at LINGER_LIMIT leaves slots free for short clips to come and go.
    function automatic int lingering_voices();
        int n;
        int s;
        n = 0;
        for (s = 0; s < VOICES; s++)
            if (slot_busy[s] && (slot_held[s] || slot_repeat[s] ||
                                 int'(slot_len[s]) - int'(slot_pos[s]) > 64))
                n++;
        return n;
    endfunction

    function automatic stim_row_t make_row(input logic [OP_W-1:0] op, input int addr,
                                           input int smp, input int len, input bit lp,
                                           input bit ps, input bit known, input int mix,
                                           input bit acc, input int cnt);
        stim_row_t row;
        row.req.op       = op;
        row.req.addr     = ADDR_W'(addr);
        row.req.smp      = SMP_IN_W'(smp);
        row.req.len      = LEN_W'(len);
        row.req.loop_f   = lp;
        row.req.paused_f = ps;
        row.known        = known;
        row.want.mix     = MIX_W'(mix);
        row.want.acc     = acc;
        row.want.count   = COUNT_W'(cnt);
        return row;
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void table_add(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // Offers one transaction and returns at the falling edge after it was
    // taken. It is always entered at a falling edge at which in_valid has not
    // been assigned yet, so valid stays high across back-to-back transactions
    // and gets at most one assignment per time step. The sender works in
    // bursts; between bursts it may drop valid and idle.
    task automatic send_item(input mix_req_t req, input logic known, input mix_frame_t want);
        mix_frame_t got;
        int         gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        operation    <= req.op;
        address      <= req.addr;
        sample_in    <= req.smp;
        clip_length  <= req.len;
        loop_flag    <= req.loop_f;
        start_paused <= req.paused_f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Accepted at this edge. The model always advances; a typed-in
        // expectation, where the table has one, takes the place of its frame.
        got = mixer_advance(req);
        pending_frames.insert(pending_frames.size(), known ? want : got);
        if (req.op != OP_UNUSED)
        begin
            issued++;
            if (issued == HOLD_AT)
                hold_request = 1'b1;
        end
        @(negedge clk);
    endtask

    // The sender goes quiet until every expected frame has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_frames.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        mix_req_t        req;
        mix_req_t        fill;
        int              pick;
        int              r;
        int              s;
        bit              drained;
        bit [ADDR_W-1:0] a;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_WRITE;
        address      = '0;
        sample_in    = '0;
        clip_length  = '0;
        loop_flag    = 1'b0;
        start_paused = 1'b0;
        drained      = 1'b0;

        // Directed table. Columns: operation, address, sample, length, loop,
        // paused, expectation typed in, then mix, accepted and voice count.
        // Store the two sample extremes at the two address extremes, plus
        // one ordinary word for the looping voice further down.
        table_add(make_row(OP_WRITE, 0, 32767, 0, 0, 0, 1, 0, 1, 0));
        table_add(make_row(OP_WRITE, 65535, -32768, 0, 0, 0, 1, 0, 1, 0));
        table_add(make_row(OP_WRITE, 1, 1234, 0, 0, 0, 1, 0, 1, 0));
        // The undecoded operation, with every other field all ones.
        table_add(make_row(OP_UNUSED, 65535, -1, 131071, 1, 1, 1, 0, 0, 0));
        // Refused starts: zero length, the largest length field, one past the
        // largest legal clip.
        table_add(make_row(OP_START, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        table_add(make_row(OP_START, 0, 0, 131071, 0, 0, 1, 0, 0, 0));
        table_add(make_row(OP_START, 0, 0, 65537, 0, 0, 1, 0, 0, 0));
        // A tick with every slot free mixes to zero.
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, 1, 0));
        // Fill every slot with a two-sample one-shot clip based at the top
        // address, so its second sample wraps around to address zero.
        for (s = 1; s <= VOICES; s++)
            table_add(make_row(OP_START, 65535, 0, 2, 0, 0, 1, 0, 1, s));
        // No free slot left.
        table_add(make_row(OP_START, 0, 0, 1, 0, 0, 1, 0, 0, VOICES));
        // Full negative swing, then full positive swing; the clips end and
        // every slot is released after the second tick.
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 1, -262144, 1, VOICES));
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 1, 262136, 1, 0));
        // A paused voice holds slot zero and is never read; a looping voice
        // over addresses zero and one takes slot one.
        table_add(make_row(OP_START, 100, 0, 3, 0, 1, 1, 0, 1, 1));
        table_add(make_row(OP_START, 0, 0, 2, 1, 0, 1, 0, 1, 2));
        // The loop wraps: these ticks are left to the model.
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        table_add(make_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_item(directed_rows[k].req, directed_rows[k].known, directed_rows[k].want);
        wait_drained();

        // Random part. Most traffic is writes, starts of short one-shot clips
        // and ticks; a few starts are refused, loop, pause or run long, and a
        // few transactions carry the undecoded operation. Before each tick,
        // any word a playing voice is about to read that has never been
        // stored gets a write first, so no unwritten word is ever read.
        while (issued < ITEM_TARGET)
        begin
            if (!drained && issued >= DRAIN_AT)
            begin
                drained = 1'b1;
                wait_drained();
            end
            pick         = $urandom_range(0, 99);
            req.addr     = ($urandom_range(0, 1) != 0) ? ADDR_W'($urandom_range(0, 255))
                                                       : ADDR_W'($urandom);
            req.smp      = SMP_IN_W'($urandom);
            req.len      = LEN_W'($urandom);
            req.loop_f   = 1'($urandom_range(0, 1));
            req.paused_f = 1'($urandom_range(0, 1));
            if (pick < 3)
                req.op = OP_UNUSED;
            else if (pick < 33)
                req.op = OP_WRITE;
            else if (pick < 58)
            begin
                req.op = OP_START;
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    // Refused on length; the flags stay random.
                    if (r < 4)
                        req.len = '0;
                    else
                        req.len = LEN_W'($urandom_range(MAX_CLIP + 1, (1 << LEN_W) - 1));
                end
                else
                begin
                    req.loop_f   = 1'b0;
                    req.paused_f = 1'b0;
                    if (r < 24 && lingering_voices() < LINGER_LIMIT)
                    begin
                        if (r < 12)
                            req.len = MAX_CLIP;
                        else if (r < 16)
                            req.len = LEN_W'($urandom_range(65, MAX_CLIP - 1));
                        else if (r < 20)
                        begin
                            req.len    = LEN_W'($urandom_range(1, 16));
                            req.loop_f = 1'b1;
                        end
                        else
                        begin
                            req.len      = LEN_W'($urandom_range(1, MAX_CLIP));
                            req.paused_f = 1'b1;
                        end
                    end
                    else
                        req.len = LEN_W'($urandom_range(1, 16));
                end
            end
            else
            begin
                req.op = OP_TICK;
                for (s = 0; s < VOICES; s++)
                begin
                    if (slot_busy[s] && !slot_held[s])
                    begin
                        a = slot_base[s] + slot_pos[s];
                        if (!sample_written[a])
                        begin
                            fill      = req;
                            fill.op   = OP_WRITE;
                            fill.addr = a;
                            fill.smp  = SMP_IN_W'($urandom);
                            send_item(fill, 1'b0, '0);
                        end
                    end
                end
            end
            send_item(req, 1'b0, '0);
        end

        // Let the last frames come back, then watch a while longer for any
        // frame that nobody asked for.
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("multi_voice_sample_mixer_tb: done, clean");
        else
            $display("multi_voice_sample_mixer_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side. The stall pattern switches at random between no stall,
    // light and heavy random stall, and a fixed two-in-three pattern. Once
    // in the run the sender asks for a long hold-off, which is counted here
    // while the sender keeps offering transactions, so the block fills up
    // and must stall its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int mode;
        int phase;
        int hold_left;
        out_stall = 1'b0;
        mode      = 0;
        phase     = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (phase == 0)
            begin
                mode  = $urandom_range(0, 3);
                phase = $urandom_range(20, 80);
            end
            phase--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= (phase % 3 != 0);
                endcase
            end
        end
    end

    // Every frame taken at a rising edge is checked field by field against
    // the oldest expectation.
    always @(posedge clk)
    begin : frame_check
        mix_frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("unexpected frame: mix %0d accepted %0d voices %0d",
                                          mix_out, accepted, active_voices));
            else
            begin
                want = pending_frames.pop_front();
                if (mix_out !== want.mix)
                    report_mismatch($sformatf("mix_out %0d, expected %0d",
                                              mix_out, $signed(want.mix)));
                if (accepted !== want.acc)
                    report_mismatch($sformatf("accepted %0d, expected %0d",
                                              accepted, want.acc));
                if (active_voices !== want.count)
                    report_mismatch($sformatf("active_voices %0d, expected %0d",
                                              active_voices, want.count));
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #1_000_000;
        $display("multi_voice_sample_mixer_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
src/mvsm_pkg.sv
src/mvsm_ram.sv
src/multi_voice_sample_mixer.sv
src/mvsm_checker.sv
tb/sv/multi_voice_sample_mixer_tb.sv
